// ----- sv/acfp_pkg.sv -----
package acfp_pkg;

	// Field and register widths.
	localparam int unsigned FIELD_W = 16;
	localparam int unsigned ID_W    = 7;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned INDEX_W = 2;
	localparam int unsigned DATA_W  = 7;

	// Control mode codes.
	localparam logic [MODE_W-1:0] MODE_POSITION = 2'd0;
	localparam logic [MODE_W-1:0] MODE_VELOCITY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TORQUE   = 2'd2;

	// Register indexes on the write port.
	localparam logic [INDEX_W-1:0] REG_CONTROL_MODE  = 2'd0;
	localparam logic [INDEX_W-1:0] REG_DRIVE_ENABLED = 2'd1;
	localparam logic [INDEX_W-1:0] REG_TRANSMIT_HOLD = 2'd2;
	localparam logic [INDEX_W-1:0] REG_TARGET_ID     = 2'd3;

	localparam logic [ID_W-1:0] TARGET_ID_RESET = 7'd1;

	// One lane per packed field, in frame order.
	localparam int unsigned NUM_LANES = 5;
	localparam int unsigned LANE_POS  = 0;
	localparam int unsigned LANE_VEL  = 1;
	localparam int unsigned LANE_KP   = 2;
	localparam int unsigned LANE_KD   = 3;
	localparam int unsigned LANE_TRQ  = 4;

	// Datapath widths of the scaling lanes.
	localparam int unsigned RAW_W       = FIELD_W + 1;
	localparam int unsigned OFF_W       = 16;
	localparam int unsigned CONST_W     = 17;
	localparam int unsigned NUM_W       = 33;
	localparam int unsigned RECIP_W     = 19;
	localparam int unsigned PROD_W      = NUM_W + RECIP_W;
	localparam int unsigned RECIP_SHIFT = 34;
	localparam int unsigned CODE_W      = 16;
	localparam int unsigned SHORT_W     = 12;

	// Protocol limits in the input field's own fixed-point units.
	localparam int LANE_LO [NUM_LANES] = '{-25736, -30720, 0, 0, -18432};
	localparam int LANE_HI [NUM_LANES] = '{25736, 30720, 32000, 25600, 18432};

	// Full-scale code of each lane.
	localparam int unsigned LANE_FULL [NUM_LANES] = '{65535, 4095, 4095, 4095, 4095};

	// Span of each lane, and the rounding divisor of twice the span.
	localparam int unsigned LANE_SPAN [NUM_LANES] = '{51472, 61440, 32000, 25600, 36864};
	localparam int unsigned LANE_DIV [NUM_LANES] = '{102944, 122880, 64000, 51200, 73728};

	// Reciprocals of the divisors, rounded down, scaled by two to the RECIP_SHIFT.
	localparam longint unsigned LANE_RECIP [NUM_LANES] = '{
		(64'd1 << RECIP_SHIFT) / 64'd102944,
		(64'd1 << RECIP_SHIFT) / 64'd122880,
		(64'd1 << RECIP_SHIFT) / 64'd64000,
		(64'd1 << RECIP_SHIFT) / 64'd51200,
		(64'd1 << RECIP_SHIFT) / 64'd73728
	};

	typedef struct packed {
		logic signed [FIELD_W-1:0] position_cmd;
		logic signed [FIELD_W-1:0] velocity_cmd;
		logic [FIELD_W-1:0]        stiffness_gain;
		logic [FIELD_W-1:0]        damping_gain;
		logic signed [FIELD_W-1:0] torque_cmd;
	} setpoint_t;

	typedef struct packed {
		logic [63:0]     frame_payload;
		logic [ID_W-1:0] dest_id;
	} result_t;

	typedef struct packed {
		logic [MODE_W-1:0] control_mode;
		logic              drive_enabled;
		logic              transmit_hold;
		logic [ID_W-1:0]   target_id;
	} cfg_t;

	typedef logic [NUM_LANES-1:0][OFF_W-1:0]  lane_off_t;
	typedef logic [NUM_LANES-1:0][CODE_W-1:0] lane_code_t;

endpackage

// ----- sv/acfp_front.sv -----
module acfp_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  acfp_pkg::cfg_t          cfg,
	input  acfp_pkg::setpoint_t     setpoint,
	output logic                    valid_s1,
	output acfp_pkg::lane_off_t     off_s1,
	output logic [acfp_pkg::ID_W-1:0] id_s1
);
	import acfp_pkg::*;

	logic signed [RAW_W-1:0] raw [NUM_LANES];
	lane_off_t               off_d;
	logic                    keep_pos;
	logic                    keep_vel;
	logic                    keep_kp;
	logic                    keep_kd;
	logic                    keep_trq;

	always_comb begin
		keep_pos = 1'b0;
		keep_vel = 1'b0;
		keep_kp  = 1'b0;
		keep_kd  = 1'b0;
		keep_trq = 1'b0;
		case (cfg.control_mode)
			MODE_POSITION: begin
				keep_pos = 1'b1;
				keep_kp  = 1'b1;
				keep_kd  = 1'b1;
			end
			MODE_VELOCITY: begin
				keep_vel = 1'b1;
				keep_kd  = 1'b1;
			end
			MODE_TORQUE: begin
				keep_trq = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Fields the mode drops are treated as value zero, which still yields a code.
	always_comb begin
		raw[LANE_POS] = keep_pos ?
			{setpoint.position_cmd[FIELD_W-1], setpoint.position_cmd} : '0;
		raw[LANE_VEL] = keep_vel ?
			{setpoint.velocity_cmd[FIELD_W-1], setpoint.velocity_cmd} : '0;
		raw[LANE_KP]  = keep_kp ? {1'b0, setpoint.stiffness_gain} : '0;
		raw[LANE_KD]  = keep_kd ? {1'b0, setpoint.damping_gain} : '0;
		raw[LANE_TRQ] = keep_trq ?
			{setpoint.torque_cmd[FIELD_W-1], setpoint.torque_cmd} : '0;
	end

	for (genvar lane = 0; lane < NUM_LANES; lane++) begin : g_clamp
		localparam logic signed [RAW_W-1:0] LO = RAW_W'(LANE_LO[lane]);
		localparam logic signed [RAW_W-1:0] HI = RAW_W'(LANE_HI[lane]);

		logic signed [RAW_W-1:0] clamped;
		logic [RAW_W-1:0]        diff;

		always_comb begin
			if (raw[lane] < LO) begin
				clamped = LO;
			end else if (raw[lane] > HI) begin
				clamped = HI;
			end else begin
				clamped = raw[lane];
			end
		end

		// Offset from the lower limit never exceeds the span, so it fits OFF_W bits.
		assign diff        = clamped - LO;
		assign off_d[lane] = diff[OFF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && cfg.drive_enabled && !cfg.transmit_hold;
		end
	end

	always_ff @(posedge clk) begin
		off_s1 <= off_d;
		id_s1  <= cfg.target_id;
	end

endmodule

// ----- sv/acfp_scale.sv -----
module acfp_scale (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  acfp_pkg::lane_off_t       off_s1,
	input  logic [acfp_pkg::ID_W-1:0] id_s1,
	output logic                      valid_s5,
	output acfp_pkg::lane_code_t      code,
	output logic [acfp_pkg::ID_W-1:0] id_s5
);
	import acfp_pkg::*;

	logic            valid_s2;
	logic            valid_s3;
	logic            valid_s4;
	logic [ID_W-1:0] id_s2;
	logic [ID_W-1:0] id_s3;
	logic [ID_W-1:0] id_s4;

	// Each lane computes floor((off * 2F + S) / 2S): numerator, reciprocal estimate,
	// back-multiplication, then a single correction step.
	for (genvar lane = 0; lane < NUM_LANES; lane++) begin : g_lane
		localparam logic [CONST_W-1:0] TWICE_FULL = CONST_W'(2 * LANE_FULL[lane]);
		localparam logic [CONST_W-1:0] SPAN       = CONST_W'(LANE_SPAN[lane]);
		localparam logic [CONST_W-1:0] DIV        = CONST_W'(LANE_DIV[lane]);
		localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(LANE_RECIP[lane]);

		logic [NUM_W-1:0]  num_s2;
		logic [NUM_W-1:0]  num_s3;
		logic [NUM_W-1:0]  num_s4;
		logic [PROD_W-1:0] prod;
		logic [CODE_W-1:0] est_s3;
		logic [CODE_W-1:0] est_s4;
		logic [NUM_W-1:0]  back_s4;
		logic [NUM_W-1:0]  rem;
		logic [CODE_W-1:0] code_s5;

		// The reciprocal is rounded down and the numerator stays below two to the
		// shift, so the estimate is the true quotient or one short of it.
		assign prod = PROD_W'(num_s2) * PROD_W'(RECIP);
		assign rem  = num_s4 - back_s4;

		always_ff @(posedge clk) begin
			num_s2  <= NUM_W'(off_s1[lane]) * NUM_W'(TWICE_FULL) + NUM_W'(SPAN);
			num_s3  <= num_s2;
			est_s3  <= prod[RECIP_SHIFT +: CODE_W];
			num_s4  <= num_s3;
			est_s4  <= est_s3;
			back_s4 <= NUM_W'(est_s3) * NUM_W'(DIV);
			code_s5 <= est_s4 + CODE_W'(rem >= NUM_W'(DIV));
		end

		assign code[lane] = code_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		id_s2 <= id_s1;
		id_s3 <= id_s2;
		id_s4 <= id_s3;
		id_s5 <= id_s4;
	end

`ifndef SYNTHESIS
	a_valid_travels: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 4) |-> valid_s5 == $past(valid_s1, 4))
		else $error("valid bit lost or duplicated in the scaling pipeline");

	a_short_codes_fit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (code[LANE_VEL][CODE_W-1:SHORT_W] == '0)
			&& (code[LANE_KP][CODE_W-1:SHORT_W] == '0)
			&& (code[LANE_KD][CODE_W-1:SHORT_W] == '0)
			&& (code[LANE_TRQ][CODE_W-1:SHORT_W] == '0))
		else $error("twelve-bit code overflowed its field");
`endif

endmodule

// ----- sv/actuator_command_frame_packer.sv -----
// An accepted request, when the drive is enabled and transmit hold is clear, yields its
// frame on result, with done high for one cycle, once it has passed registers s1 to s5.
// Throughput: one request per cycle; busy is always low and the five-stage pipeline of
// clamp, numerator, reciprocal multiply, back-multiply and correction never stalls.
// Reset clears the pipeline valid bits and returns the registers to their defaults.
module actuator_command_frame_packer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  acfp_pkg::setpoint_t          setpoint,
	output logic                         done,
	output acfp_pkg::result_t            result,
	input  logic                         wr_en,
	input  logic [acfp_pkg::INDEX_W-1:0] wr_index,
	input  logic [acfp_pkg::DATA_W-1:0]  wr_data
);
	import acfp_pkg::*;

	cfg_t            cfg_q;
	logic            accept;
	logic            valid_s1;
	lane_off_t       off_s1;
	logic [ID_W-1:0] id_s1;
	lane_code_t      code;
	logic [ID_W-1:0] id_s5;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control_mode  <= MODE_POSITION;
			cfg_q.drive_enabled <= 1'b0;
			cfg_q.transmit_hold <= 1'b0;
			cfg_q.target_id     <= TARGET_ID_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_CONTROL_MODE:  cfg_q.control_mode  <= wr_data[MODE_W-1:0];
				REG_DRIVE_ENABLED: cfg_q.drive_enabled <= wr_data[0];
				REG_TRANSMIT_HOLD: cfg_q.transmit_hold <= wr_data[0];
				REG_TARGET_ID:     cfg_q.target_id     <= wr_data[ID_W-1:0];
				default: begin
				end
			endcase
		end
	end

	acfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cfg      (cfg_q),
		.setpoint (setpoint),
		.valid_s1 (valid_s1),
		.off_s1   (off_s1),
		.id_s1    (id_s1)
	);

	acfp_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.off_s1   (off_s1),
		.id_s1    (id_s1),
		.valid_s5 (done),
		.code     (code),
		.id_s5    (id_s5)
	);

	// Big-endian frame: position takes the top two bytes, the rest twelve bits each.
	always_comb begin
		result.frame_payload = {
			code[LANE_POS],
			code[LANE_VEL][SHORT_W-1:0],
			code[LANE_KP][SHORT_W-1:0],
			code[LANE_KD][SHORT_W-1:0],
			code[LANE_TRQ][SHORT_W-1:0]
		};
		result.dest_id = id_s5;
	end

`ifndef SYNTHESIS
	a_frame_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, 5) |->
			done == $past(accept && cfg_q.drive_enabled && !cfg_q.transmit_hold, 5))
		else $error("frame emitted without an enabled request five cycles earlier");
`endif

endmodule
